### src/wsrd_pkg.sv
// shared types, constants and ring index helpers for the work-stealing ring deque
// no dependencies

package wsrd_pkg;

   localparam int Depth       = 256;
   localparam int AddrWidth   = $clog2(Depth);
   localparam int CountWidth  = $clog2(Depth + 1);
   localparam int HandleWidth = 32;
   localparam int StealMin    = 2;

   typedef enum logic [1:0] {
      OP_PUSH  = 2'd0,
      OP_POP   = 2'd1,
      OP_STEAL = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_FULL = 2'd1,
      ST_NONE = 2'd2
   } status_type;

   typedef struct packed {
      op_type                 op;
      logic [HandleWidth-1:0] handle_in;
   } req_type;

   typedef struct packed {
      status_type             status;
      logic [HandleWidth-1:0] handle_out;
      logic [CountWidth-1:0]  entry_count;
   } rsp_type;

   // slot memory access for one item
   typedef struct packed {
      logic                   wr_en;
      logic [AddrWidth-1:0]   wr_addr;
      logic [HandleWidth-1:0] wr_data;
      logic                   rd_en;
      logic [AddrWidth-1:0]   rd_addr;
   } ram_cmd_type;

   // result of one item, less the handle that the slot memory returns later
   typedef struct packed {
      status_type            status;
      logic                  take;
      logic [CountWidth-1:0] count;
   } meta_type;

   function automatic logic [AddrWidth-1:0] ring_next(input logic [AddrWidth-1:0] idx);
      logic [AddrWidth-1:0] res;
      if (idx == AddrWidth'(Depth - 1)) begin
         res = '0;
      end else begin
         res = idx + AddrWidth'(1);
      end
      return res;
   endfunction

   function automatic logic [AddrWidth-1:0] ring_prev(input logic [AddrWidth-1:0] idx);
      logic [AddrWidth-1:0] res;
      if (idx == '0) begin
         res = AddrWidth'(Depth - 1);
      end else begin
         res = idx - AddrWidth'(1);
      end
      return res;
   endfunction

endpackage

### src/work_stealing_ring_deque.sv
// top level of the work-stealing ring deque: request/response pipeline
// depends on wsrd_pkg, wsrd_ctrl and wsrd_ram

// Bounded deque of 32-bit task handles for one worker of a work-stealing
// scheduler, held in a ring of wsrd_pkg::Depth slots. Each request item gives
// exactly one response item. A push stores a handle at the rear, or answers
// full. A pop takes the newest handle from the rear, or answers none when
// empty. A steal takes the oldest handle from the front only while two or more
// entries are held. Every response carries the entry count after the request.
// One request is taken every cycle while req_stall is low; its response is
// held in stage one alongside the registered read of the slot memory, then
// leaves the output register. The slots need no clearing after reset, as only
// written entries are ever read. Stall on the response side holds the response
// register; it shows up on req_stall in the same cycle once both pipeline
// stages hold an item, while an empty stage still takes one more request.

module work_stealing_ring_deque (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  wsrd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output wsrd_pkg::rsp_type rsp_data
);

   import wsrd_pkg::*;

   // handshake and pipeline control
   logic        accept;
   logic        s1_advance;
   ram_cmd_type ram_cmd;
   meta_type    meta;
   logic [HandleWidth-1:0] rd_data;

   // stage one: item metadata while the slot memory read is in flight
   logic     s1_valid_ff, s1_valid_in;
   meta_type s1_meta_ff;

   // stage two: the response register
   logic    s2_valid_ff, s2_valid_in;
   rsp_type s2_data_ff, s2_data_in;

   // stage one may move on when the response register is free or being taken
   assign s1_advance = !s2_valid_ff || !rsp_stall;
   assign req_stall  = s1_valid_ff && !s1_advance;
   assign accept     = req_valid && !req_stall;

   wsrd_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .req     (req_data),
      .ram_cmd (ram_cmd),
      .meta    (meta)
   );

   // read data only changes on an accepted item, so it holds while stage one waits
   wsrd_ram #(
      .Width (HandleWidth),
      .Depth (Depth)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_cmd.wr_en),
      .wr_addr (ram_cmd.wr_addr),
      .wr_data (ram_cmd.wr_data),
      .rd_en   (ram_cmd.rd_en),
      .rd_addr (ram_cmd.rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end

      s2_valid_in = s2_valid_ff;
      if (s1_advance) begin
         s2_valid_in = s1_valid_ff;
      end

      // handle is zero for every push and every failed request
      s2_data_in.status      = s1_meta_ff.status;
      s2_data_in.handle_out  = s1_meta_ff.take ? rd_data : '0;
      s2_data_in.entry_count = s1_meta_ff.count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_meta_ff <= meta;
      end
      if (s1_advance && s1_valid_ff) begin
         s2_data_ff <= s2_data_in;
      end
   end

   assign rsp_valid = s2_valid_ff;
   assign rsp_data  = s2_data_ff;

   a_fail_no_handle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ST_OK) |-> (rsp_data.handle_out == '0))
      else $error("failed request returned a handle");

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && s2_valid_ff))
      else $error("request stalled with room in the pipeline");

endmodule

### src/wsrd_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies

module wsrd_ram #(
   parameter int Width = 32,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/wsrd_ctrl.sv
// front/rear index and entry count control of the ring deque
// depends on wsrd_pkg

module wsrd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  wsrd_pkg::req_type     req,
   output wsrd_pkg::ram_cmd_type ram_cmd,
   output wsrd_pkg::meta_type    meta
);

   import wsrd_pkg::*;

   logic [AddrWidth-1:0]  front_ff, front_in;
   logic [AddrWidth-1:0]  rear_ff, rear_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [AddrWidth-1:0]  rear_back;

   assign rear_back = ring_prev(rear_ff);

   always_comb begin
      front_in      = front_ff;
      rear_in       = rear_ff;
      count_in      = count_ff;
      ram_cmd       = '0;
      meta.status   = ST_NONE;
      meta.take     = 1'b0;
      case (req.op)
         OP_PUSH: begin
            if (count_ff == CountWidth'(Depth)) begin
               meta.status = ST_FULL;
            end else begin
               ram_cmd.wr_en   = accept;
               ram_cmd.wr_addr = rear_ff;
               ram_cmd.wr_data = req.handle_in;
               rear_in         = ring_next(rear_ff);
               count_in        = count_ff + CountWidth'(1);
               meta.status     = ST_OK;
            end
         end
         OP_POP: begin
            // newest entry sits just behind the rear index
            if (count_ff != '0) begin
               ram_cmd.rd_en   = accept;
               ram_cmd.rd_addr = rear_back;
               rear_in         = rear_back;
               count_in        = count_ff - CountWidth'(1);
               meta.status     = ST_OK;
               meta.take       = 1'b1;
            end
         end
         OP_STEAL: begin
            if (count_ff >= CountWidth'(StealMin)) begin
               ram_cmd.rd_en   = accept;
               ram_cmd.rd_addr = front_ff;
               front_in        = ring_next(front_ff);
               count_in        = count_ff - CountWidth'(1);
               meta.status     = ST_OK;
               meta.take       = 1'b1;
            end
         end
         default: begin
         end
      endcase
      meta.count = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         rear_ff  <= '0;
         count_ff <= '0;
      end else if (accept) begin
         front_ff <= front_in;
         rear_ff  <= rear_in;
         count_ff <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountWidth'(Depth))
      else $error("entry count beyond depth");

   a_index_meet: assert property (@(posedge clock) disable iff (reset)
      (front_ff == rear_ff) |-> (count_ff == '0 || count_ff == CountWidth'(Depth)))
      else $error("indices meet with a partly filled deque");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (accept && req.op == OP_PUSH && meta.status == ST_OK)
         |=> (count_ff == $past(count_ff) + CountWidth'(1)))
      else $error("successful push did not grow the count");

endmodule

### bench/tb.sv
// self-checking bench for the work-stealing ring deque: push, pop and steal traffic
// depends on wsrd_pkg and work_stealing_ring_deque from the rtl

`timescale 1ns / 100ps

module tb;
   import wsrd_pkg::*;

   // spare opcode, expected to be treated as a no-op by the block
   localparam logic [1:0] OpCodeUnused = 2'd3;
   localparam int unsigned TotalItems  = 1850;
   localparam int unsigned MaxIdle     = 11;
   // a response passes stage one and the output register, so this tail is generous
   localparam int unsigned TailCycles  = 12;
   // worst honest gap is a sender wait plus a receiver stall plus latency
   localparam int unsigned QuietLimit  = 2000;

   // mirror of the deque plus the queue of responses still owed by the block
   class deque_scoreboard;
      logic [HandleWidth-1:0] slot_copy [Depth];
      logic [AddrWidth-1:0]   head_idx = '0;
      logic [AddrWidth-1:0]   tail_idx = '0;
      int unsigned            held = 0;
      rsp_type                owed_rsp [$];
      int unsigned            error_count = 0;
      int unsigned            ok_count = 0;
      int unsigned            full_count = 0;
      int unsigned            none_count = 0;
      int unsigned            peak_held = 0;
      int unsigned            checked_count = 0;

      // work out the response an accepted request must give
      function void note_request(input req_type item);
         rsp_type want;
         want.status     = ST_NONE;
         want.handle_out = '0;
         case (item.op)
            OP_PUSH: begin
               if (held >= Depth) begin
                  want.status = ST_FULL;
               end else begin
                  slot_copy[tail_idx] = item.handle_in;
                  tail_idx = AddrWidth'((int'(tail_idx) + 1) % Depth);
                  held++;
                  want.status = ST_OK;
               end
            end
            OP_POP: begin
               if (held != 0) begin
                  tail_idx = AddrWidth'((int'(tail_idx) + Depth - 1) % Depth);
                  want.handle_out = slot_copy[tail_idx];
                  held--;
                  want.status = ST_OK;
               end
            end
            OP_STEAL: begin
               if (held >= StealMin) begin
                  want.handle_out = slot_copy[head_idx];
                  head_idx = AddrWidth'((int'(head_idx) + 1) % Depth);
                  held--;
                  want.status = ST_OK;
               end
            end
            default: begin
               want.status = ST_NONE;
            end
         endcase
         want.entry_count = CountWidth'(held);
         case (want.status)
            ST_OK:   ok_count++;
            ST_FULL: full_count++;
            default: none_count++;
         endcase
         if (held > peak_held) peak_held = held;
         owed_rsp.push_back(want);
      endfunction

      // compare one accepted response against the oldest one owed
      function void check_response(input rsp_type got);
         rsp_type want;
         if (owed_rsp.size() == 0) begin
            $error("unexpected response: status %0d handle_out %h entry_count %0d",
                   got.status, got.handle_out, got.entry_count);
            error_count++;
            return;
         end
         want = owed_rsp.pop_front();
         checked_count++;
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            error_count++;
         end
         if (got.handle_out !== want.handle_out) begin
            $error("handle_out: expected %h, got %h", want.handle_out, got.handle_out);
            error_count++;
         end
         if (got.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
            error_count++;
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   deque_scoreboard tracker;
   int unsigned     items_sent = 0;
   bit              tx_idle = 1'b1;
   bit              rx_idle = 1'b1;
   int unsigned     stall_left = 0;
   int unsigned     stall_draw;
   int unsigned     quiet_cycles = 0;

   work_stealing_ring_deque DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // both channels watched from one block so a request is always noted
   // before any response in the same edge is checked
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) tracker.note_request(req_data);
         if (rsp_valid && !rsp_stall) tracker.check_response(rsp_data);
      end
   end

   // receiver: after each item taken, hold stall for a drawn number of cycles
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         stall_draw = rx_idle ? $urandom_range(0, MaxIdle) : 0;
         rsp_stall  <= (stall_draw != 0);
         stall_left <= (stall_draw != 0) ? stall_draw - 1 : 0;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // watchdog on cycles where neither channel moves an item
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // mostly random handles, with the all-zero and all-one patterns mixed in
   function automatic logic [HandleWidth-1:0] draw_handle();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return '1;
         default: return $urandom();
      endcase
   endfunction

   // present one item, after an optional idle gap, and wait for it to be taken;
   // valid stays high straight into the next item when there is no gap
   task automatic send_item(input op_type op, input logic [HandleWidth-1:0] handle);
      int unsigned gap;
      req_type     item;
      gap            = tx_idle ? $urandom_range(0, MaxIdle) : 0;
      item.op        = op;
      item.handle_in = handle;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   // sender holds off until every owed response has come back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (tracker.owed_rsp.size() != 0);
   endtask

   // edge cases on a fresh deque: empty pops and steals, the single-entry
   // steal refusal, the spare opcode and the extreme handle values
   task automatic run_directed();
      send_item(OP_POP, 32'h1234_5678);
      send_item(OP_STEAL, 32'hFFFF_FFFF);
      send_item(op_type'(OpCodeUnused), 32'hDEAD_BEEF);
      send_item(OP_PUSH, 32'h0000_0000);
      send_item(OP_STEAL, 32'h0);
      send_item(OP_POP, 32'h0);
      send_item(OP_PUSH, 32'hFFFF_FFFF);
      send_item(OP_PUSH, 32'hA5A5_5A5A);
      send_item(OP_PUSH, 32'h5A5A_A5A5);
      send_item(OP_STEAL, 32'h0);
      send_item(op_type'(OpCodeUnused), 32'hFFFF_FFFF);
      send_item(OP_STEAL, 32'h0);
      send_item(OP_STEAL, 32'h0);
      send_item(OP_POP, 32'hFFFF_FFFF);
      send_item(OP_POP, 32'h0);
      send_item(OP_PUSH, 32'h8000_0001);
      send_item(OP_POP, 32'h0);
   endtask

   // one stretch of traffic with a given bias towards pushes
   task automatic run_segment(input int unsigned push_pct, input int unsigned odd_pct,
                              input int unsigned len);
      int unsigned pick;
      for (int unsigned i = 0; i < len; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < push_pct) begin
            send_item(OP_PUSH, draw_handle());
         end else if ($urandom_range(0, 99) < odd_pct) begin
            send_item(op_type'(OpCodeUnused), draw_handle());
         end else if ($urandom_range(0, 1) == 0) begin
            send_item(OP_POP, draw_handle());
         end else begin
            send_item(OP_STEAL, draw_handle());
         end
      end
   endtask

   // a fill to full, a drain to empty, then segments of random bias so the
   // ring wraps and visits both ends several times
   task automatic run_random();
      int unsigned bias_levels [5] = '{95, 75, 50, 25, 5};
      int unsigned seg;
      int unsigned push_pct;
      int unsigned odd_pct;
      int unsigned len;
      seg = 0;
      while (items_sent < TotalItems) begin
         if (seg == 0) begin
            push_pct = 95;
            len      = 320;
         end else if (seg == 1) begin
            push_pct = 5;
            len      = 320;
         end else begin
            push_pct = bias_levels[$urandom_range(0, 4)];
            len      = $urandom_range(40, 250);
         end
         if (len > TotalItems - items_sent) len = TotalItems - items_sent;
         odd_pct = ($urandom_range(0, 3) == 0) ? 4 : 0;
         // some segments run flat out on one side or both
         tx_idle = ($urandom_range(0, 2) != 0);
         rx_idle <= ($urandom_range(0, 2) != 0);
         run_segment(push_pct, odd_pct, len);
         if ($urandom_range(0, 2) == 0) wait_for_results();
         seg++;
      end
   endtask

   initial begin
      tracker = new;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      // sender pause until the pipeline is empty
      wait_for_results();
      run_random();
      wait_for_results();
      repeat (TailCycles) @(posedge clock);
      $display("run covered %0d requests: %0d succeeded, %0d refused as full, %0d found nothing",
               items_sent, tracker.ok_count, tracker.full_count, tracker.none_count);
      $display("deepest fill %0d of %0d slots, %0d responses checked",
               tracker.peak_held, Depth, tracker.checked_count);
      if (tracker.error_count == 0 && tracker.owed_rsp.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
